>>> hdl/stq_pkg.sv
// stq_pkg: shared types, codes and constants for the sorted timer queue
// no dependencies; imported by stq_mem, stq_cmp, sorted_timer_queue and tb_top
`default_nettype none

package stq_pkg;

    // default number of timer slots
    localparam int DEPTH_DEFAULT = 16;
    // most handles released by one tick request
    localparam int MAX_RESULTS   = 16;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_ADJUST = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_TICK   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_EXPIRED = 3'd0,
        ST_OK      = 3'd1,
        ST_FULL    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_DUP     = 3'd4
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  timer_handle;
        logic [31:0] expiry_time;
        logic [31:0] current_time;
    } request_t;

    typedef struct packed {
        logic [7:0] result_handle;
        status_t    status;
        logic       last;
    } result_t;

    // one queue slot
    typedef struct packed {
        logic [31:0] expiry;
        logic [7:0]  handle;
    } entry_t;

    // compare unit outputs
    typedef struct packed {
        logic hit;  // slot handle equals key handle
        logic le;   // slot expiry at most key time
    } cmp_res_t;

endpackage

`default_nettype wire

>>> hdl/stq_mem.sv
// stq_mem: slot store of the timer queue, one write and one registered read port
// depends on stq_pkg for the slot type
`default_nettype none

module stq_mem
    import stq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [IW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [IW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/stq_cmp.sv
// stq_cmp: shared compare unit, handle match and expiry ordering of one slot
// depends on stq_pkg for the slot and result types
`default_nettype none

module stq_cmp
    import stq_pkg::*;
(
    input  wire entry_t      slot,
    input  wire logic [31:0] key_time,
    input  wire logic [7:0]  key_handle,
    output cmp_res_t         res
);

    always_comb
    begin
        res.hit = (slot.handle == key_handle);
        res.le  = (slot.expiry <= key_time);
    end

endmodule

`default_nettype wire

>>> hdl/sorted_timer_queue.sv
// sorted_timer_queue: top level, sequencer around the slot store and compare unit
// depends on stq_pkg, stq_mem and stq_cmp
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+---------------------------------------
//  request  | start, busy, request       | taken on a clock edge with start & !busy
//  result   | result_valid, result       | each result valid for a single cycle, cannot be held off
//
// - add, adjust and delete: an accept step, a scan of each queued slot, a decide
//   step, a move of each slot that must shift, a write (add and adjust only) and
//   a status step; the single read port of the slot store is why the scan and
//   the moves go one slot at a time
// - tick: a scan of each slot examined, a flush step, then a move of each slot
//   left behind to close the gap at the head; handles come out one per cycle
// - reset clears only the control state and entry count; the slot store needs
//   no clearing pass as only slots below the entry count are used
// - busy is high from the accept until the status step, or for a tick the last
//   move or flush, is done; the final result may appear once busy has dropped
`default_nettype none

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          result_valid,
    output result_t       result
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KMAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] KMAX_C  = CW'(KMAX);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_TFLUSH = 7'b0001000,
        S_COPY   = 7'b0010000,
        S_PLACE  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          res_valid_reg, res_valid_next;

    // per-request working registers
    req_type_t     op_reg, op_next;
    logic [31:0]   key_exp_reg, key_exp_next;
    logic [7:0]    key_hdl_reg, key_hdl_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic          found_reg, found_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] k_reg, k_next;
    logic [7:0]    pend_reg, pend_next;
    logic [IW-1:0] src_reg, src_next;
    logic [IW-1:0] dst_reg, dst_next;
    logic [CW-1:0] n_reg, n_next;
    logic          down_reg, down_next;
    logic [IW-1:0] place_reg, place_next;
    logic          do_place_reg, do_place_next;
    status_t       status_reg, status_next;
    result_t       res_reg, res_next;

    // slot store and compare unit hookup
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [IW-1:0] mem_raddr;
    entry_t        rd_data;
    cmp_res_t      cmp;

    logic          scan_end;
    logic          tick_take;

    stq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    stq_cmp u_cmp (
        .slot       (rd_data),
        .key_time   (key_exp_reg),
        .key_handle (key_hdl_reg),
        .res        (cmp)
    );

    // scan has reached the last occupied slot
    assign scan_end  = ((CW'(scan_reg) + CW'(1)) == cnt_reg);
    // scanned slot expired and the per-tick limit not yet reached
    assign tick_take = cmp.le && (k_reg != KMAX_C);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        op_next        = op_reg;
        key_exp_next   = key_exp_reg;
        key_hdl_next   = key_hdl_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        n_next         = n_reg;
        down_next      = down_reg;
        place_next     = place_reg;
        do_place_next  = do_place_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = dst_reg;
        mem_wdata      = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = request.req_type;
                    key_hdl_next = request.timer_handle;
                    key_exp_next = (request.req_type == REQ_TICK) ?
                                   request.current_time : request.expiry_time;
                    scan_next    = '0;
                    found_next   = 1'b0;
                    fidx_next    = '0;
                    pos_next     = '0;
                    k_next       = '0;
                    if (cnt_reg == '0)
                    begin
                        // empty queue: tick does nothing, others decide at once
                        state_next = (request.req_type == REQ_TICK) ? S_IDLE : S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                scan_next = scan_reg + IW'(1);
                if (op_reg == REQ_TICK)
                begin
                    if (tick_take)
                    begin
                        k_next    = k_reg + CW'(1);
                        pend_next = rd_data.handle;
                        // a handle is only released once we know another follows
                        if (k_reg != '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = '{result_handle: pend_reg,
                                               status: ST_EXPIRED, last: 1'b0};
                        end
                    end
                    if (!tick_take || scan_end)
                    begin
                        state_next = S_TFLUSH;
                    end
                end
                else
                begin
                    // match position, and insertion point among the other slots
                    if (cmp.hit)
                    begin
                        found_next = 1'b1;
                        fidx_next  = scan_reg;
                    end
                    else if (cmp.le)
                    begin
                        pos_next = pos_reg + CW'(1);
                    end
                    if (scan_end)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_TFLUSH:
            begin
                cnt_next      = cnt_reg - k_reg;
                do_place_next = 1'b0;
                if (k_reg != '0)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{result_handle: pend_reg,
                                       status: ST_EXPIRED, last: 1'b1};
                end
                if ((k_reg != '0) && (cnt_reg != k_reg))
                begin
                    // close the gap left at the head
                    src_next   = IW'(k_reg);
                    dst_next   = '0;
                    n_next     = cnt_reg - k_reg;
                    down_next  = 1'b0;
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_DECIDE:
            begin
                status_next   = ST_OK;
                place_next    = IW'(pos_reg);
                do_place_next = 1'b0;
                state_next    = S_DONE;
                case (op_reg)
                    REQ_ADD:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (cnt_reg == DEPTH_C)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cnt_next      = cnt_reg + CW'(1);
                            do_place_next = 1'b1;
                            if (pos_reg != cnt_reg)
                            begin
                                // open a gap at the insertion point
                                src_next   = IW'(cnt_reg - CW'(1));
                                dst_next   = IW'(cnt_reg);
                                n_next     = cnt_reg - pos_reg;
                                down_next  = 1'b1;
                                state_next = S_COPY;
                            end
                            else
                            begin
                                state_next = S_PLACE;
                            end
                        end
                    end

                    REQ_ADJUST:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_UNKNOWN;
                        end
                        else
                        begin
                            do_place_next = 1'b1;
                            if (pos_reg >= CW'(fidx_reg))
                            begin
                                // later expiry: pull the slots in between forward
                                n_next    = pos_reg - CW'(fidx_reg);
                                src_next  = fidx_reg + IW'(1);
                                dst_next  = fidx_reg;
                                down_next = 1'b0;
                                state_next = (pos_reg == CW'(fidx_reg)) ? S_PLACE : S_COPY;
                            end
                            else
                            begin
                                // earlier expiry: push the slots in between back
                                n_next     = CW'(fidx_reg) - pos_reg;
                                src_next   = fidx_reg - IW'(1);
                                dst_next   = fidx_reg;
                                down_next  = 1'b1;
                                state_next = S_COPY;
                            end
                        end
                    end

                    REQ_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_UNKNOWN;
                        end
                        else
                        begin
                            cnt_next  = cnt_reg - CW'(1);
                            n_next    = cnt_reg - CW'(1) - CW'(fidx_reg);
                            src_next  = fidx_reg + IW'(1);
                            dst_next  = fidx_reg;
                            down_next = 1'b0;
                            if (cnt_reg - CW'(1) != CW'(fidx_reg))
                            begin
                                state_next = S_COPY;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_COPY:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rd_data;
                src_next  = down_reg ? (src_reg - IW'(1)) : (src_reg + IW'(1));
                dst_next  = down_reg ? (dst_reg - IW'(1)) : (dst_reg + IW'(1));
                n_next    = n_reg - CW'(1);
                if (n_reg == CW'(1))
                begin
                    if (do_place_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = (op_reg == REQ_TICK) ? S_IDLE : S_DONE;
                    end
                end
            end

            S_PLACE:
            begin
                mem_we           = 1'b1;
                mem_waddr        = place_reg;
                mem_wdata.expiry = key_exp_reg;
                mem_wdata.handle = key_hdl_reg;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                res_valid_next = 1'b1;
                res_next       = '{result_handle: key_hdl_reg,
                                   status: status_reg, last: 1'b1};
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read address runs one step ahead of the slot being looked at
    always_comb
    begin
        case (state_reg)
            S_IDLE:  mem_raddr = '0;
            S_SCAN:  mem_raddr = scan_reg + IW'(1);
            default: mem_raddr = src_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_exp_reg  <= key_exp_next;
        key_hdl_reg  <= key_hdl_next;
        scan_reg     <= scan_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        pend_reg     <= pend_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        n_reg        <= n_next;
        down_reg     <= down_next;
        place_reg    <= place_next;
        do_place_reg <= do_place_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_EXPIRED)) |-> result.last)
        else $error("status result without last");

    a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.req_type == REQ_TICK) && (cnt_reg == '0))
        |=> (!busy && !result_valid))
        else $error("tick on empty queue did work");

    a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> (n_reg != '0))
        else $error("slot move with zero length");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for sorted_timer_queue, directed table then random requests
// depends on stq_pkg and sorted_timer_queue; results checked against an in-bench timer list
`default_nettype none

module tb_top
    import stq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int CLK_PERIOD   = 8;
    // worst request: scan, decide, move every slot, write, status
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    // watchdog limit for the whole run, leaving plenty of room
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PER_PHASE = 60;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // one row of the directed table: a request and, where obvious, its single answer
    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  want;
    } stim_row_t;

    localparam int NUM_ROWS = 14;

    // empty queue misses, extremes, duplicate, equal expiry order,
    // adjust in both directions, tick with nothing due, tick that empties
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{'{REQ_DELETE, 8'd7,   32'd0,    32'd0},    1'b1, '{8'd7,   ST_UNKNOWN, 1'b1}},
        '{'{REQ_ADJUST, 8'd7,   32'd9,    32'd0},    1'b1, '{8'd7,   ST_UNKNOWN, 1'b1}},
        '{'{REQ_TICK,   8'd0,   32'd0,    TIME_MAX}, 1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_ADD,    8'd0,   32'd0,    32'd0},    1'b1, '{8'd0,   ST_OK,      1'b1}},
        '{'{REQ_ADD,    8'd255, TIME_MAX, 32'd0},    1'b1, '{8'd255, ST_OK,      1'b1}},
        '{'{REQ_ADD,    8'd0,   32'd5,    32'd0},    1'b1, '{8'd0,   ST_DUP,     1'b1}},
        '{'{REQ_ADD,    8'd10,  32'd100,  32'd0},    1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_ADD,    8'd11,  32'd100,  32'd0},    1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_ADD,    8'd12,  32'd50,   32'd0},    1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_ADJUST, 8'd12,  32'd100,  32'd0},    1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_ADJUST, 8'd255, 32'd0,    32'd0},    1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_DELETE, 8'd11,  32'd0,    32'd0},    1'b1, '{8'd11,  ST_OK,      1'b1}},
        '{'{REQ_TICK,   8'd0,   32'd0,    32'd0},    1'b0, '{8'd0,   ST_EXPIRED, 1'b0}},
        '{'{REQ_TICK,   8'd0,   32'd0,    TIME_MAX}, 1'b0, '{8'd0,   ST_EXPIRED, 1'b0}}
    };

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     result_valid;
    result_t  result;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_timer_queue #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // timer list held by the bench, slot 0 is the head
    // ------------------------------------------------------------------
    logic [31:0] slot_exp [DEPTH];
    logic [7:0]  slot_hdl [DEPTH];
    int          slot_used = 0;

    // answers still owed by the block, oldest first
    result_t     due_results [$];

    int          fail_count = 0;
    int unsigned cycle_count = 0;
    // rough notion of "now" so random expiries and ticks land near each other
    logic [31:0] wall_time = 32'd1000;

    function automatic int find_timer(logic [7:0] h);
        for (int i = 0; i < slot_used; i++)
            if (slot_hdl[i] == h)
                return i;
        return -1;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < slot_used; i++)
        begin
            slot_exp[i] = slot_exp[i + 1];
            slot_hdl[i] = slot_hdl[i + 1];
        end
        slot_used--;
    endfunction

    // goes after every entry whose expiry is at most the new one
    function automatic void place_timer(logic [7:0] h, logic [31:0] exp);
        int pos;
        pos = 0;
        while (pos < slot_used && slot_exp[pos] <= exp)
            pos++;
        for (int i = slot_used; i > pos; i--)
        begin
            slot_exp[i] = slot_exp[i - 1];
            slot_hdl[i] = slot_hdl[i - 1];
        end
        slot_exp[pos] = exp;
        slot_hdl[pos] = h;
        slot_used++;
    endfunction

    function automatic void owe_status(logic [7:0] h, status_t st);
        result_t r;
        r.result_handle = h;
        r.status        = st;
        r.last          = 1'b1;
        due_results.push_back(r);
    endfunction

    // update the timer list for one accepted request and queue what it owes
    function automatic void apply_timer_request(request_t r);
        int      pos;
        int      n;
        logic    fin;
        result_t hit;
        case (r.req_type)
            REQ_ADD:
            begin
                if (find_timer(r.timer_handle) >= 0)
                    owe_status(r.timer_handle, ST_DUP);
                else if (slot_used >= DEPTH)
                    owe_status(r.timer_handle, ST_FULL);
                else
                begin
                    place_timer(r.timer_handle, r.expiry_time);
                    owe_status(r.timer_handle, ST_OK);
                end
            end
            REQ_ADJUST, REQ_DELETE:
            begin
                pos = find_timer(r.timer_handle);
                if (pos < 0)
                    owe_status(r.timer_handle, ST_UNKNOWN);
                else
                begin
                    drop_slot(pos);
                    if (r.req_type == REQ_ADJUST)
                        place_timer(r.timer_handle, r.expiry_time);
                    owe_status(r.timer_handle, ST_OK);
                end
            end
            default:
            begin
                n = 0;
                while (n < MAX_RESULTS && slot_used > 0 && slot_exp[0] <= r.current_time)
                begin
                    hit.result_handle = slot_hdl[0];
                    hit.status        = ST_EXPIRED;
                    drop_slot(0);
                    n++;
                    fin = !(n < MAX_RESULTS && slot_used > 0
                            && slot_exp[0] <= r.current_time);
                    hit.last = fin;
                    due_results.push_back(hit);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // random request generation
    // ------------------------------------------------------------------
    // mostly near the running time so ties and expiries are common,
    // sometimes the extremes or any value at all
    function automatic logic [31:0] pick_time(logic [31:0] base);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 32'd0;
        if (roll < 10)
            return TIME_MAX;
        if (roll < 20)
            return $urandom;
        return base + $urandom_range(0, 63);
    endfunction

    function automatic logic [7:0] pick_live_handle();
        return slot_hdl[$urandom_range(0, slot_used - 1)];
    endfunction

    function automatic request_t make_request();
        request_t    r;
        int unsigned roll;
        roll           = $urandom_range(0, 99);
        r.timer_handle = 8'($urandom_range(0, 255));
        r.expiry_time  = $urandom;
        r.current_time = $urandom;
        if (roll < 40)
        begin
            r.req_type = REQ_ADD;
            if (slot_used > 0 && $urandom_range(0, 99) < 15)
                r.timer_handle = pick_live_handle();
            else if ($urandom_range(0, 1) == 0)
                r.timer_handle = 8'($urandom_range(0, 31));
            r.expiry_time = pick_time(wall_time);
        end
        else if (roll < 75)
        begin
            r.req_type = (roll < 58) ? REQ_ADJUST : REQ_DELETE;
            // mostly hit a live timer, otherwise a random handle that usually misses
            if (slot_used > 0 && $urandom_range(0, 99) < 80)
                r.timer_handle = pick_live_handle();
            r.expiry_time = pick_time(wall_time);
        end
        else
        begin
            r.req_type     = REQ_TICK;
            wall_time      = wall_time + $urandom_range(0, 24);
            r.current_time = pick_time(wall_time);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // present one request, optionally after a gap, and hold it until taken;
    // start is left high so back-to-back requests need no extra edge
    task automatic send_request(input request_t r, input logic typed, input result_t want,
                                input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        apply_timer_request(r);
        // where the answer is typed in the table it replaces the computed one
        if (typed)
        begin
            void'(due_results.pop_back());
            due_results.push_back(want);
        end
    endtask

    // stop offering requests and let every owed result arrive
    task automatic settle();
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // fill every slot, bounce one add off the full queue and one duplicate,
    // then expire the lot with a single tick
    task automatic fill_and_flush(input int idle_pct);
        request_t    r;
        logic [7:0]  first;
        first = 8'($urandom_range(0, 255));
        r.current_time = $urandom;
        for (int i = 0; i <= DEPTH + 1; i++)
        begin
            r.req_type     = REQ_ADD;
            r.timer_handle = first + 8'(13 * i);
            if (i == DEPTH + 1)
                r.timer_handle = first;
            r.expiry_time  = pick_time(wall_time);
            send_request(r, 1'b0, '0, idle_pct);
        end
        r.req_type     = REQ_TICK;
        r.current_time = TIME_MAX;
        send_request(r, 1'b0, '0, idle_pct);
    endtask

    // ------------------------------------------------------------------
    // result side: every strobe must match the oldest owed result
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    result_t oldest_due;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (due_results.size() == 0)
                flag_mismatch("unrequested result, handle", -1, int'(result.result_handle));
            else
            begin
                oldest_due = due_results.pop_front();
                if (result.result_handle !== oldest_due.result_handle)
                    flag_mismatch("result_handle", int'(oldest_due.result_handle),
                                  int'(result.result_handle));
                if (result.status !== oldest_due.status)
                    flag_mismatch("status", int'(oldest_due.status), int'(result.status));
                if (result.last !== oldest_due.last)
                    flag_mismatch("last", int'(oldest_due.last), int'(result.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int idle_pct;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling so requests follow each other closely
        for (int i = 0; i < NUM_ROWS; i++)
            send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want, 0);
        settle();

        // random phases: light sender gaps, heavy gaps, then none at all
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 26 : (phase == 1) ? 58 : 0;
            fill_and_flush(idle_pct);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 99) < 3)
                    settle();
                send_request(make_request(), 1'b0, '0, idle_pct);
            end
            settle();
        end

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
